[rtl/zs_strip_word_decoder_assert.svh]
// Assertion macros for the strip word decoder.
`ifndef ZS_STRIP_WORD_DECODER_ASSERT_SVH
`define ZS_STRIP_WORD_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ZSD_ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("zsd assertion failed");

// Next-cycle implication, checked out of reset.
`define ZSD_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("zsd assertion failed");

`endif

[rtl/zsd_pkg.sv]
`timescale 1ns / 1ps

package zsd_pkg;

    // word type, bits 28:27
    localparam logic [1:0] WT_CLUSTER = 2'd0;
    localparam logic [1:0] WT_STUB    = 2'd1;
    localparam logic [1:0] WT_STATUS  = 2'd2;

    // record kinds
    localparam logic [1:0] KIND_CLUSTER = 2'd0;
    localparam logic [1:0] KIND_HIT     = 2'd1;
    localparam logic [1:0] KIND_STUB    = 2'd2;
    localparam logic [1:0] KIND_STATUS  = 2'd3;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic [1:0] kind;
        logic       last;
        logic       set_sel;
        logic       sel_val;
        logic       clr_hit;
        logic       inc_hit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] wtype;
        logic [1:0] mask;
        logic       sel;
        logic       hit_end;
    } t_sts;

endpackage

[rtl/zsd_ctrl.sv]
`timescale 1ns / 1ps

module zsd_ctrl
    import zsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_CLUS   = 2'd2;
    localparam logic [1:0] S_HIT    = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.wtype)
                    WT_CLUSTER: begin
                        if (i_sts.mask != 2'b00) begin
                            o_cmd.set_sel = 1'b1;
                            o_cmd.sel_val = ~i_sts.mask[0];
                            n_state       = S_CLUS;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    WT_STUB: begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = KIND_STUB;
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                    WT_STATUS: begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = KIND_STATUS;
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_CLUS: begin
                o_cmd.emit    = 1'b1;
                o_cmd.kind    = KIND_CLUSTER;
                o_cmd.clr_hit = 1'b1;
                n_state       = S_HIT;
            end
            S_HIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = KIND_HIT;
                if (!i_sts.hit_end) begin
                    o_cmd.inc_hit = 1'b1;
                end else if (!i_sts.sel && i_sts.mask[1]) begin
                    o_cmd.set_sel = 1'b1;
                    o_cmd.sel_val = 1'b1;
                    n_state       = S_CLUS;
                end else begin
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE) || !i_rst_n;

endmodule

[rtl/zsd_datapath.sv]
`timescale 1ns / 1ps

module zsd_datapath
    import zsd_pkg::*;
#(
    parameter int unsigned MAX_CLUSTER_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_frontend_id,
    input  logic [2:0]  i_chip_number,
    output t_sts        o_sts,
    output logic        o_strobe,
    output logic [1:0]  o_record_kind,
    output logic [2:0]  o_frontend_tag,
    output logic [2:0]  o_chip_tag,
    output logic [7:0]  o_strip_address,
    output logic [3:0]  o_cluster_size,
    output logic        o_sensor_side,
    output logic [3:0]  o_stub_bend,
    output logic [3:0]  o_stub_flags,
    output logic [8:0]  o_level1_count,
    output logic [8:0]  o_pipe_address,
    output logic [2:0]  o_level1_flags,
    output logic        o_last_record
);

    localparam logic [3:0] MaxWidth = 4'(MAX_CLUSTER_WIDTH);

    logic [31:0] r_word;
    logic [2:0]  r_fe;
    logic [2:0]  r_chip;
    logic        r_sel;
    logic [2:0]  r_hit;

    logic        r_strobe;
    logic [1:0]  r_kind;
    logic [2:0]  r_fe_tag;
    logic [2:0]  r_chip_tag;
    logic [7:0]  r_strip;
    logic [3:0]  r_size;
    logic        r_sensor;
    logic [3:0]  r_bend;
    logic [3:0]  r_sflags;
    logic [8:0]  r_l1cnt;
    logic [8:0]  r_pipe;
    logic [2:0]  r_l1flags;
    logic        r_last;

    logic [7:0]  first;
    logic [2:0]  wcode;
    logic [3:0]  width_raw;
    logic [3:0]  width;
    logic [7:0]  hit_strip;

    assign first     = r_sel ? r_word[21:14] : r_word[10:3];
    assign wcode     = r_sel ? r_word[13:11] : r_word[2:0];
    assign width_raw = {1'b0, wcode} + 4'd1;
    assign width     = (width_raw > MaxWidth) ? MaxWidth : width_raw;
    assign hit_strip = first + {4'b0000, r_hit, 1'b0};

    assign o_sts.wtype   = r_word[28:27];
    assign o_sts.mask    = r_word[25:24];
    assign o_sts.sel     = r_sel;
    assign o_sts.hit_end = (({1'b0, r_hit} + 4'd1) == width);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_data_word;
            r_fe   <= i_frontend_id;
            r_chip <= i_chip_number;
        end
        if (i_cmd.set_sel) begin
            r_sel <= i_cmd.sel_val;
        end
        if (i_cmd.clr_hit) begin
            r_hit <= 3'd0;
        end else if (i_cmd.inc_hit) begin
            r_hit <= r_hit + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind     <= i_cmd.kind;
            r_fe_tag   <= r_fe;
            r_chip_tag <= r_chip;
            r_last     <= i_cmd.last;
            r_strip    <= 8'd0;
            r_size     <= 4'd0;
            r_sensor   <= 1'b0;
            r_bend     <= 4'd0;
            r_sflags   <= 4'd0;
            r_l1cnt    <= 9'd0;
            r_pipe     <= 9'd0;
            r_l1flags  <= 3'd0;
            unique case (i_cmd.kind)
                KIND_CLUSTER: begin
                    r_strip  <= first;
                    r_size   <= width;
                    r_sensor <= first[0];
                end
                KIND_HIT: begin
                    r_strip  <= hit_strip;
                    r_sensor <= hit_strip[0];
                end
                KIND_STUB: begin
                    r_strip  <= r_word[20:13];
                    r_bend   <= r_word[9:6];
                    r_sflags <= r_word[3:0];
                end
                KIND_STATUS: begin
                    r_l1cnt   <= r_word[24:16];
                    r_pipe    <= r_word[12:4];
                    r_l1flags <= {r_word[26], r_word[1], r_word[0]};
                end
            endcase
        end
    end

    assign o_strobe        = r_strobe;
    assign o_record_kind   = r_kind;
    assign o_frontend_tag  = r_fe_tag;
    assign o_chip_tag      = r_chip_tag;
    assign o_strip_address = r_strip;
    assign o_cluster_size  = r_size;
    assign o_sensor_side   = r_sensor;
    assign o_stub_bend     = r_bend;
    assign o_stub_flags    = r_sflags;
    assign o_level1_count  = r_l1cnt;
    assign o_pipe_address  = r_pipe;
    assign o_level1_flags  = r_l1flags;
    assign o_last_record   = r_last;

endmodule

[rtl/zs_strip_word_decoder.sv]
`timescale 1ns / 1ps
// Channel   Handshake        Transfer when
// ------    ---------------  -----------------------------------
// input     start / busy     start high and busy low at clk edge
// result    o_strobe         o_strobe high, one record per strobe
//
// A word is decoded in the cycle after its transfer; records then go out one per
// cycle, each on the ports in the cycle after the controller issues it.
// Busy covers only the decode state on stub, status, type 3 and empty-mask words;
// cluster words then emit, per enabled cluster, a cluster record and width hit records.
// Reset is synchronous, active low; busy stays high while it is asserted.
// The receiver cannot stall: every strobed record is a transfer.

`include "zs_strip_word_decoder_assert.svh"

module zs_strip_word_decoder
    import zsd_pkg::*;
#(
    parameter int unsigned MAX_CLUSTER_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_frontend_id,
    input  logic [2:0]  i_chip_number,
    output logic        o_strobe,
    output logic [1:0]  o_record_kind,
    output logic [2:0]  o_frontend_tag,
    output logic [2:0]  o_chip_tag,
    output logic [7:0]  o_strip_address,
    output logic [3:0]  o_cluster_size,
    output logic        o_sensor_side,
    output logic [3:0]  o_stub_bend,
    output logic [3:0]  o_stub_flags,
    output logic [8:0]  o_level1_count,
    output logic [8:0]  o_pipe_address,
    output logic [2:0]  o_level1_flags,
    output logic        o_last_record
);

    t_cmd cmd;
    t_sts sts;

    zsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    zsd_datapath #(
        .MAX_CLUSTER_WIDTH (MAX_CLUSTER_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_data_word     (i_data_word),
        .i_frontend_id   (i_frontend_id),
        .i_chip_number   (i_chip_number),
        .o_sts           (sts),
        .o_strobe        (o_strobe),
        .o_record_kind   (o_record_kind),
        .o_frontend_tag  (o_frontend_tag),
        .o_chip_tag      (o_chip_tag),
        .o_strip_address (o_strip_address),
        .o_cluster_size  (o_cluster_size),
        .o_sensor_side   (o_sensor_side),
        .o_stub_bend     (o_stub_bend),
        .o_stub_flags    (o_stub_flags),
        .o_level1_count  (o_level1_count),
        .o_pipe_address  (o_pipe_address),
        .o_level1_flags  (o_level1_flags),
        .o_last_record   (o_last_record)
    );

    `ZSD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ZSD_ASSERT_NEXT(a_last_gap, i_clk, i_rst_n, o_strobe && o_last_record, !o_strobe)
    `ZSD_ASSERT_NEXT(a_cluster_hit, i_clk, i_rst_n,
        o_strobe && (o_record_kind == KIND_CLUSTER),
        o_strobe && (o_record_kind == KIND_HIT))
    `ZSD_ASSERT_IMPLY(a_single_last, i_clk, i_rst_n,
        o_strobe && ((o_record_kind == KIND_STUB) || (o_record_kind == KIND_STATUS)),
        o_last_record)

endmodule
